// ===== hdl/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// Cheat code encoder package
// Shared types, constants and instruction helpers for the cheat code encoder.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam logic [4:0] RegK0 = 5'd26;
  localparam logic [4:0] RegK1 = 5'd27;

  localparam logic [5:0] OpLui = 6'h0F;
  localparam logic [5:0] OpOri = 6'h0D;
  localparam logic [5:0] OpLbu = 6'h24;
  localparam logic [5:0] OpLhu = 6'h25;
  localparam logic [5:0] OpSb  = 6'h28;
  localparam logic [5:0] OpSh  = 6'h29;
  localparam logic [5:0] OpBeq = 6'h04;
  localparam logic [5:0] OpBne = 6'h05;

  localparam logic [31:0] JrK0Word  = 32'h0340_0008;
  localparam logic [31:0] AddrMask  = 32'hA07F_FFFF;
  localparam logic [31:0] HiRound   = 32'h0000_8000;
  localparam logic [3:0]  CondNib   = 4'hD;
  localparam logic [15:0] BranchOff = 16'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StCapacity = 2'd1;
  localparam logic [1:0] StAtoms    = 2'd2;
  localparam logic [1:0] StDangling = 2'd3;

  localparam logic [1:0] CfgPreFirst  = 2'd0;
  localparam logic [1:0] CfgPreSecond = 2'd1;
  localparam logic [1:0] CfgCapacity  = 2'd2;
  localparam logic [1:0] CfgAtomLimit = 2'd3;

  typedef enum logic [1:0] {
    OP_COND,
    OP_WRITE,
    OP_TAIL,
    OP_FAIL
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] val;
    logic        w16;
    logic        ne;
    logic        guarded;
    logic [1:0]  status;
    logic [7:0]  codes;
    logic [7:0]  atoms;
  } cmd_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        atom_end;
    logic [2:0]  atom_words;
    logic        last;
    logic [1:0]  status;
    logic [7:0]  code_count;
    logic [7:0]  atom_count;
  } res_t;

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

endpackage

// ===== hdl/cce_front.sv =====
// ----------------------------------------------------------------------------
// Cheat code encoder front end
// Accepts list items, runs the capacity and block checks and queues commands.
// ----------------------------------------------------------------------------
module cce_front #(
  parameter int MAX_PROGRAM_WORDS = 4095
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           kind_i,
  input  logic [31:0]    code_word_i,
  input  logic [31:0]    value_word_i,
  input  logic [11:0]    word_capacity_i,
  input  logic [7:0]     atom_limit_i,
  input  logic           q_full_i,
  output logic           push_o,
  output cce_pkg::cmd_t  cmd_o
);
  import cce_pkg::*;

  localparam logic [11:0] MaxLim = (MAX_PROGRAM_WORDS < 4095) ? 12'(MAX_PROGRAM_WORDS) : 12'hFFF;

  logic        guard_q, guard_d;
  logic [12:0] words_q, words_d;
  logic [7:0]  blocks_q, blocks_d;
  logic [7:0]  codes_q, codes_d;
  logic [1:0]  fail_q, fail_d;

  logic [11:0] lim;
  logic [31:0] addr;
  logic [31:0] hi_sum;
  logic [7:0]  ctype;
  logic        accept;
  logic        cap_tail, cap_cond, cap_write, atom_full;
  logic [1:0]  end_st;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lim        = (word_capacity_i < MaxLim) ? word_capacity_i : MaxLim;
  assign addr       = code_word_i & AddrMask;
  assign hi_sum     = addr + HiRound;
  assign ctype      = code_word_i[31:24];
  assign cap_tail   = ({1'b0, words_q} + 14'd4) > {2'b00, lim};
  assign cap_cond   = ({1'b0, words_q} + 14'd11) > {2'b00, lim};
  assign cap_write  = ({1'b0, words_q} + 14'd7) > {2'b00, lim};
  assign atom_full  = blocks_q >= atom_limit_i;

  always_comb begin
    end_st = fail_q;
    if (end_st == StOk && guard_q) begin
      end_st = StDangling;
    end
    if (end_st == StOk) begin
      if (cap_tail) begin
        end_st = StCapacity;
      end else if (atom_full) begin
        end_st = StAtoms;
      end
    end
  end

  always_comb begin
    guard_d  = guard_q;
    words_d  = words_q;
    blocks_d = blocks_q;
    codes_d  = codes_q;
    fail_d   = fail_q;
    push_o   = 1'b0;

    cmd_o.op      = OP_WRITE;
    cmd_o.hi      = hi_sum[31:16];
    cmd_o.lo      = addr[15:0];
    cmd_o.val     = ctype[0] ? value_word_i[15:0] : {8'h00, value_word_i[7:0]};
    cmd_o.w16     = ctype[0];
    cmd_o.ne      = ctype[1];
    cmd_o.guarded = guard_q;
    cmd_o.status  = end_st;
    cmd_o.codes   = codes_q;
    cmd_o.atoms   = blocks_q;

    if (accept) begin
      if (kind_i) begin
        push_o = 1'b1;
        if (end_st != StOk) begin
          cmd_o.op = OP_FAIL;
        end else begin
          cmd_o.op    = OP_TAIL;
          cmd_o.atoms = blocks_q + 8'd1;
        end
        guard_d  = 1'b0;
        words_d  = '0;
        blocks_d = '0;
        codes_d  = '0;
        fail_d   = StOk;
      end else if (fail_q == StOk) begin
        if (!guard_q && ctype[7:4] == CondNib) begin
          if (cap_cond) begin
            fail_d = StCapacity;
          end else if (atom_full) begin
            fail_d = StAtoms;
          end else begin
            push_o   = 1'b1;
            cmd_o.op = OP_COND;
            words_d  = words_q + 13'd4;
            guard_d  = 1'b1;
          end
        end else if (!guard_q && cap_write) begin
          fail_d = StCapacity;
        end else if (!guard_q && atom_full) begin
          fail_d = StAtoms;
        end else begin
          push_o   = 1'b1;
          words_d  = words_q + 13'd3;
          blocks_d = blocks_q + 8'd1;
          codes_d  = codes_q + 8'd1;
          guard_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q  <= 1'b0;
      words_q  <= '0;
      blocks_q <= '0;
      codes_q  <= '0;
      fail_q   <= StOk;
    end else begin
      guard_q  <= guard_d;
      words_q  <= words_d;
      blocks_q <= blocks_d;
      codes_q  <= codes_d;
      fail_q   <= fail_d;
    end
  end

endmodule

// ===== hdl/cce_queue.sv =====
// ----------------------------------------------------------------------------
// Cheat code encoder command queue
// Two-entry queue that decouples the front end from the word sequencer.
// ----------------------------------------------------------------------------
module cce_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cce_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cce_pkg::cmd_t  cmd_o
);
  import cce_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

// ===== hdl/cce_back.sv =====
// ----------------------------------------------------------------------------
// Cheat code encoder back end
// Expands queued commands into output words, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module cce_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  cce_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  input  logic [31:0]    preamble_first_i,
  input  logic [31:0]    preamble_second_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cce_pkg::res_t  res_o
);
  import cce_pkg::*;

  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  res_t       res_q, res_d;
  logic       load;
  logic       last_step;

  assign load        = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = load && last_step;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    res_d     = '0;
    last_step = 1'b0;
    unique case (cmd_i.op)
      OP_COND: begin
        last_step = step_q == 2'd3;
        unique case (step_q)
          2'd0: res_d.instr_word = itype(OpLui, 5'd0, RegK0, cmd_i.hi);
          2'd1: res_d.instr_word = itype(cmd_i.w16 ? OpLhu : OpLbu, RegK0, RegK0, cmd_i.lo);
          2'd2: res_d.instr_word = itype(OpOri, 5'd0, RegK1, cmd_i.val);
          default: res_d.instr_word = itype(cmd_i.ne ? OpBeq : OpBne, RegK0, RegK1, BranchOff);
        endcase
      end
      OP_WRITE: begin
        last_step = step_q == 2'd2;
        unique case (step_q)
          2'd0: res_d.instr_word = itype(OpLui, 5'd0, RegK0, cmd_i.hi);
          2'd1: res_d.instr_word = itype(OpOri, 5'd0, RegK1, cmd_i.val);
          default: begin
            res_d.instr_word = itype(cmd_i.w16 ? OpSh : OpSb, RegK0, RegK1, cmd_i.lo);
            res_d.atom_end   = 1'b1;
            res_d.atom_words = cmd_i.guarded ? 3'd7 : 3'd3;
          end
        endcase
      end
      OP_TAIL: begin
        last_step = step_q == 2'd3;
        unique case (step_q)
          2'd0: res_d.instr_word = preamble_first_i;
          2'd1: res_d.instr_word = preamble_second_i;
          2'd2: res_d.instr_word = JrK0Word;
          default: begin
            res_d.atom_end   = 1'b1;
            res_d.atom_words = 3'd4;
            res_d.last       = 1'b1;
            res_d.status     = StOk;
            res_d.code_count = cmd_i.codes;
            res_d.atom_count = cmd_i.atoms;
          end
        endcase
      end
      default: begin
        last_step        = 1'b1;
        res_d.last       = 1'b1;
        res_d.status     = cmd_i.status;
        res_d.code_count = cmd_i.codes;
        res_d.atom_count = cmd_i.atoms;
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = last_step ? 2'd0 : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/cheat_code_to_mips_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Cheat code to MIPS encoder
// Turns a list of cheat lines into a short MIPS program using only k0 and k1.
// ----------------------------------------------------------------------------
// A conditional line yields four words, a write line three and the end item
// a four-word tail, or a single status result if the list failed. Words leave
// through a registered output at one word per cycle unless out_ready_i stalls
// them; the output sequencer sets that rate. The front end checks and
// classifies each item and hands it to the sequencer through a two-entry queue,
// so input items keep being taken while earlier words are still going out, as
// long as the queue has room. Items that fail or are swallowed after a failure
// produce no words.
// Configuration writes are taken every cycle.
module cheat_code_to_mips_encoder_unit #(
  parameter int MAX_PROGRAM_WORDS = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] code_word_i,
  input  logic [31:0] value_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] instr_word_o,
  output logic        atom_end_o,
  output logic [2:0]  atom_words_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [7:0]  code_count_o,
  output logic [7:0]  atom_count_o
);
  import cce_pkg::*;

  logic [31:0] pre_first_q, pre_second_q;
  logic [11:0] capacity_q;
  logic [7:0]  atom_limit_q;

  logic q_full, q_valid, push, pop;
  cmd_t push_cmd, head_cmd;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_first_q  <= '0;
      pre_second_q <= '0;
      capacity_q   <= 12'd512;
      atom_limit_q <= 8'd48;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPreFirst:  pre_first_q  <= cfg_data_i;
        CfgPreSecond: pre_second_q <= cfg_data_i;
        CfgCapacity:  capacity_q   <= cfg_data_i[11:0];
        default:      atom_limit_q <= cfg_data_i[7:0];
      endcase
    end
  end

  cce_front #(
    .MAX_PROGRAM_WORDS(MAX_PROGRAM_WORDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .code_word_i    (code_word_i),
    .value_word_i   (value_word_i),
    .word_capacity_i(capacity_q),
    .atom_limit_i   (atom_limit_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  cce_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  cce_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .cmd_i            (head_cmd),
    .pop_o            (pop),
    .preamble_first_i (pre_first_q),
    .preamble_second_i(pre_second_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .res_o            (res)
  );

  assign instr_word_o = res.instr_word;
  assign atom_end_o   = res.atom_end;
  assign atom_words_o = res.atom_words;
  assign last_o       = res.last;
  assign status_o     = res.status;
  assign code_count_o = res.code_count;
  assign atom_count_o = res.atom_count;

endmodule

// ===== sim/tb_cheat_code_to_mips_encoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cheat code to MIPS encoder testbench
// A directed table covers the extremes, every line type, the capacity, atom
// limit and dangling conditional failures, then random cheat lists run under
// four idling phases. Every output item is checked against a local encoder.
// ----------------------------------------------------------------------------
module tb_cheat_code_to_mips_encoder_unit;
  import cce_pkg::*;

  localparam int MaxWords = 4095;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 8;
  localparam int PhaseLines = 66;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_e;

  typedef struct {
    row_e        what;
    logic        kind;
    logic [1:0]  idx;
    logic [31:0] code;
    logic [31:0] value;
    bit          typed;
    res_t        want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [31:0] code_word_i = '0;
  logic [31:0] value_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] instr_word_o;
  logic        atom_end_o;
  logic [2:0]  atom_words_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic [7:0]  code_count_o;
  logic [7:0]  atom_count_o;

  logic [31:0] pre_first = '0;
  logic [31:0] pre_second = '0;
  logic [11:0] cap_reg = 12'd512;
  logic [7:0]  atom_lim = 8'd48;
  logic        guard_pend = 1'b0;
  logic [12:0] words_out = '0;
  logic [7:0]  blocks_cnt = '0;
  logic [7:0]  codes_cnt = '0;
  logic [1:0]  fail_st = StOk;

  res_t words_due[$];
  res_t due;
  row_t plan[$];
  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   busy_lines = 0;

  cheat_code_to_mips_encoder_unit #(
    .MAX_PROGRAM_WORDS(MaxWords)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .code_word_i,
    .value_word_i,
    .out_valid_o,
    .out_ready_i,
    .instr_word_o,
    .atom_end_o,
    .atom_words_o,
    .last_o,
    .status_o,
    .code_count_o,
    .atom_count_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  function automatic res_t plain_word(logic [31:0] w);
    return '{w, 1'b0, 3'd0, 1'b0, StOk, 8'd0, 8'd0};
  endfunction

  function automatic res_t fail_word(logic [1:0] st, logic [7:0] codes, logic [7:0] atoms);
    return '{32'h0, 1'b0, 3'd0, 1'b1, st, codes, atoms};
  endfunction

  task automatic encode_line(input logic k, input logic [31:0] code, input logic [31:0] val,
                             output res_t r [4], output int n);
    logic [7:0]  typ;
    logic [31:0] addr;
    logic [31:0] hsum;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] imm;
    logic        w16;
    int          lim;
    typ = code[31:24];
    addr = code & AddrMask;
    hsum = addr + HiRound;
    hi = hsum[31:16];
    lo = addr[15:0];
    w16 = typ[0];
    imm = w16 ? val[15:0] : {8'h00, val[7:0]};
    lim = (int'(cap_reg) < MaxWords) ? int'(cap_reg) : MaxWords;
    n = 0;
    for (int i = 0; i < 4; i++) r[i] = '0;
    if (k) begin
      if (fail_st == StOk && guard_pend) fail_st = StDangling;
      if (fail_st == StOk) begin
        if (int'(words_out) + 4 > lim) fail_st = StCapacity;
        else if (blocks_cnt >= atom_lim) fail_st = StAtoms;
      end
      if (fail_st != StOk) begin
        r[0] = fail_word(fail_st, codes_cnt, blocks_cnt);
        n = 1;
      end else begin
        r[0] = plain_word(pre_first);
        r[1] = plain_word(pre_second);
        r[2] = plain_word(JrK0Word);
        r[3] = '{32'h0, 1'b1, 3'd4, 1'b1, StOk, codes_cnt, blocks_cnt + 8'd1};
        n = 4;
      end
      guard_pend = 1'b0;
      words_out = '0;
      blocks_cnt = '0;
      codes_cnt = '0;
      fail_st = StOk;
    end else if (fail_st == StOk) begin
      if (!guard_pend && typ[7:4] == CondNib) begin
        if (int'(words_out) + 11 > lim) fail_st = StCapacity;
        else if (blocks_cnt >= atom_lim) fail_st = StAtoms;
        else begin
          r[0] = plain_word({OpLui, 5'd0, RegK0, hi});
          r[1] = plain_word({w16 ? OpLhu : OpLbu, RegK0, RegK0, lo});
          r[2] = plain_word({OpOri, 5'd0, RegK1, imm});
          r[3] = plain_word({typ[1] ? OpBeq : OpBne, RegK0, RegK1, BranchOff});
          words_out = words_out + 13'd4;
          guard_pend = 1'b1;
          n = 4;
        end
      end else begin
        if (!guard_pend && int'(words_out) + 7 > lim) fail_st = StCapacity;
        else if (!guard_pend && blocks_cnt >= atom_lim) fail_st = StAtoms;
        else begin
          r[0] = plain_word({OpLui, 5'd0, RegK0, hi});
          r[1] = plain_word({OpOri, 5'd0, RegK1, imm});
          r[2] = '{{w16 ? OpSh : OpSb, RegK0, RegK1, lo}, 1'b1,
                   guard_pend ? 3'd7 : 3'd3, 1'b0, StOk, 8'd0, 8'd0};
          words_out = words_out + 13'd3;
          blocks_cnt = blocks_cnt + 8'd1;
          codes_cnt = codes_cnt + 8'd1;
          guard_pend = 1'b0;
          n = 3;
        end
      end
    end
  endtask

  task automatic send_item(input logic k, input logic [31:0] code, input logic [31:0] val,
                           input bit typed, input res_t want, output int n);
    res_t words [4];
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    code_word_i <= code;
    value_word_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    encode_line(k, code, val, words, n);
    if (typed && n > 0) words[0] = want;
    for (int i = 0; i < n; i++) words_due.push_back(words[i]);
  endtask

  task automatic send_rand(input logic k, input logic [31:0] code, input logic [31:0] val);
    int n;
    send_item(k, code, val, 1'b0, '0, n);
    if (n > 0) busy_lines++;
  endtask

  task automatic drain();
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgPreFirst:  pre_first = data;
      CfgPreSecond: pre_second = data;
      CfgCapacity:  cap_reg = data[11:0];
      CfgAtomLimit: atom_lim = data[7:0];
      default: ;
    endcase
  endtask

  task automatic random_regs();
    logic [31:0] cap;
    logic [31:0] lim;
    case ($urandom_range(3))
      0: cap = $urandom_range(16, 80);
      1: cap = 32'd512;
      2: cap = 32'd4095;
      default: cap = $urandom_range(4095);
    endcase
    case ($urandom_range(3))
      0: lim = $urandom_range(1, 8);
      1: lim = 32'd48;
      2: lim = 32'd255;
      default: lim = $urandom_range(255);
    endcase
    in_valid_i <= 1'b0;
    drain();
    write_reg(CfgPreFirst, $urandom);
    write_reg(CfgPreSecond, $urandom);
    write_reg(CfgCapacity, cap);
    write_reg(CfgAtomLimit, lim);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_item(logic k, logic [31:0] code, logic [31:0] val);
    plan.push_back('{ROW_ITEM, k, 2'd0, code, val, 1'b0, '0});
  endfunction

  function automatic void add_check(logic k, logic [31:0] code, logic [31:0] val, res_t want);
    plan.push_back('{ROW_ITEM, k, 2'd0, code, val, 1'b1, want});
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic [31:0] data);
    plan.push_back('{ROW_CFG, 1'b0, idx, data, 32'h0, 1'b0, '0});
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (words_due.size() == 0) begin
        $error("unexpected item: instr_word %08h last %0d", instr_word_o, last_o);
        fail_cnt++;
      end else begin
        due = words_due.pop_front();
        if (instr_word_o !== due.instr_word) begin
          $error("instr_word: expected %08h, got %08h", due.instr_word, instr_word_o);
          fail_cnt++;
        end
        if (atom_end_o !== due.atom_end) begin
          $error("atom_end: expected %0d, got %0d", due.atom_end, atom_end_o);
          fail_cnt++;
        end
        if (atom_words_o !== due.atom_words) begin
          $error("atom_words: expected %0d, got %0d", due.atom_words, atom_words_o);
          fail_cnt++;
        end
        if (last_o !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, last_o);
          fail_cnt++;
        end
        if (status_o !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status_o);
          fail_cnt++;
        end
        if (code_count_o !== due.code_count) begin
          $error("code_count: expected %0d, got %0d", due.code_count, code_count_o);
          fail_cnt++;
        end
        if (atom_count_o !== due.atom_count) begin
          $error("atom_count: expected %0d, got %0d", due.atom_count, atom_count_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int          n;
    int          gap_tab [4];
    int          stall_tab [4];
    logic [7:0]  typ;
    int          sel;
    gap_tab = '{0, 60, 0, 6};
    stall_tab = '{0, 0, 60, 6};

    add_check(1'b1, 32'h0, 32'h0, plain_word(32'h0));
    add_check(1'b0, 32'h0, 32'h0, plain_word(32'h3C1A_0000));
    add_item(1'b0, 32'hD012_3456, 32'hFFFF_FFFF);
    add_item(1'b0, 32'hD3FF_FFFF, 32'h1234_5678);
    add_item(1'b0, 32'hD3FF_FFFF, 32'h0000_0000);
    add_item(1'b0, 32'h81FF_FFFF, 32'h0000_FFFF);
    add_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(1'b0, 32'hD200_0000, 32'h0000_0080);
    add_check(1'b1, 32'h0, 32'h0, fail_word(StDangling, 8'd4, 8'd4));
    add_reg(CfgPreFirst, 32'hFFFF_FFFF);
    add_reg(CfgPreSecond, 32'h0);
    add_reg(CfgCapacity, 32'd15);
    add_item(1'b0, 32'hD100_0010, 32'h0000_ABCD);
    add_item(1'b0, 32'h8000_0010, 32'h0000_0001);
    add_item(1'b0, 32'h0000_0020, 32'h0000_0002);
    add_item(1'b0, 32'h0000_0030, 32'h0000_0003);
    add_item(1'b0, 32'hD000_0040, 32'h0000_0004);
    add_check(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, fail_word(StCapacity, 8'd2, 8'd2));
    add_reg(CfgCapacity, 32'd4095);
    add_reg(CfgAtomLimit, 32'd1);
    add_item(1'b0, 32'h0123_4567, 32'h0000_00FF);
    add_item(1'b0, 32'h0123_4568, 32'h0000_00FF);
    add_check(1'b1, 32'h0, 32'h0, fail_word(StAtoms, 8'd1, 8'd1));
    add_reg(CfgAtomLimit, 32'd0);
    add_check(1'b1, 32'h0, 32'h0, fail_word(StAtoms, 8'd0, 8'd0));
    add_reg(CfgCapacity, 32'd0);
    add_check(1'b1, 32'h0, 32'h0, fail_word(StCapacity, 8'd0, 8'd0));
    add_reg(CfgCapacity, 32'd4);
    add_reg(CfgAtomLimit, 32'd255);
    add_check(1'b1, 32'h0, 32'h0, plain_word(32'hFFFF_FFFF));
    add_reg(CfgCapacity, 32'd10);
    add_item(1'b0, 32'hD000_0000, 32'h0000_0000);
    add_check(1'b1, 32'h0, 32'h0, fail_word(StCapacity, 8'd0, 8'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].what == ROW_CFG) begin
        in_valid_i <= 1'b0;
        drain();
        write_reg(plan[i].idx, plan[i].code);
        cfg_valid_i <= 1'b0;
      end else begin
        send_item(plan[i].kind, plan[i].code, plan[i].value, plan[i].typed, plan[i].want, n);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_tab[ph];
      stall_pct = stall_tab[ph];
      busy_lines = 0;
      random_regs();
      while (busy_lines < PhaseLines) begin
        if ($urandom_range(3) == 0) random_regs();
        repeat ($urandom_range(1, 10)) begin
          sel = $urandom_range(99);
          if (sel < 35) begin
            send_rand(1'b0, {CondNib, 4'($urandom), 24'($urandom)}, $urandom);
            send_rand(1'b0, $urandom, $urandom);
          end else if (sel < 85) begin
            typ = 8'($urandom);
            if (typ[7:4] == CondNib) typ[4] = 1'b0;
            send_rand(1'b0, {typ, 24'($urandom)}, $urandom);
          end else if (sel < 92) begin
            send_rand(1'b0, {CondNib, 4'($urandom), 24'($urandom)}, $urandom);
          end else begin
            send_rand(1'($urandom_range(1)), $urandom, $urandom);
          end
        end
        send_rand(1'b1, $urandom, $urandom);
      end
    end

    in_valid_i <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && words_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
